### hw/rtl/idrf_pkg.sv
// ----------------------------------------------------------------------------
// idrf_pkg
// Shared types, constants and helpers of the image difference region finder.
// ----------------------------------------------------------------------------
package idrf_pkg;

  // geometry and table size
  localparam int MAX_SIDE    = 4096;
  localparam int RECTS       = 16;
  localparam int RIDX_W      = $clog2(RECTS);
  localparam int XW          = 12;   // column / row coordinate
  localparam int EW          = 13;   // sizes, extents, register width
  localparam int SW          = 14;   // coordinate plus extent
  localparam int DIST_W      = 8;
  localparam int PIX_W       = 24;
  localparam int CFG_ADDR_W  = 2;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 56;
  localparam int OUT_PAD_W   = OUT_TDATA_W - (2 * XW + 2 * EW + 1);

  // reset values of the registers
  localparam logic [EW-1:0]     FRAME_WIDTH_RST  = EW'(640);
  localparam logic [EW-1:0]     FRAME_HEIGHT_RST = EW'(480);
  localparam logic [DIST_W-1:0] NEAR_DIST_RST    = DIST_W'(5);

  // register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_MARK_ENABLE  = 2'd2,
    REG_NEAR_DIST    = 2'd3
  } cfg_reg_t;

  // result kinds
  typedef enum logic [1:0] {
    KIND_POINT  = 2'd0,
    KIND_BOX    = 2'd1,
    KIND_RECT   = 2'd2,
    KIND_NODIFF = 2'd3
  } kind_t;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_GROUP,
    ST_POINT,
    ST_BOX,
    ST_SCAN
  } state_t;

  // configuration registers
  typedef struct packed {
    logic [EW-1:0]     frame_width;
    logic [EW-1:0]     frame_height;
    logic              mark_enable;
    logic [DIST_W-1:0] near_distance;
  } cfg_t;

  // controller to datapath commands
  typedef struct packed {
    logic accept;      // latch position, step counters
    logic eval;        // update box, register proximity matches
    logic group;       // extend, allocate or flag overflow
    logic load_point;
    logic load_box;
    logic load_rect;
    logic step;        // advance readout index
    logic clear;       // reset frame state
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic in_diff;       // pixels on the input differ
    logic in_frame_end;  // input pixel is the last of the frame
    logic frame_end;     // latched pixel is the last of the frame
    logic out_free;      // output register can take a result
    logic any_used;      // some rectangle entry in use
    logic idx_used;      // readout entry in use
    logic idx_final;     // no used entry above readout entry
  } sts_t;

  // zero acts as one, oversize clamps
  function automatic logic [EW-1:0] eff_size(input logic [EW-1:0] s);
    logic [EW-1:0] r;
    r = s;
    if (s == '0) begin
      r = EW'(1);
    end else if (s > EW'(MAX_SIDE)) begin
      r = EW'(MAX_SIDE);
    end
    return r;
  endfunction

endpackage

### hw/rtl/idrf_ctrl.sv
// ----------------------------------------------------------------------------
// idrf_ctrl
// Sequencer: accepts pixel pairs, steps grouping and frame-end readout.
// ----------------------------------------------------------------------------
module idrf_ctrl
  import idrf_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_tvalid,
  output logic   in_tready,
  input  sts_t   sts,
  output cmd_t   cmd
);

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          if (sts.in_diff) begin
            state_nxt = ST_EVAL;
          end else if (sts.in_frame_end) begin
            state_nxt = ST_BOX;
          end
        end
      end
      ST_EVAL:  state_nxt = ST_GROUP;
      ST_GROUP: state_nxt = ST_POINT;
      ST_POINT: begin
        if (sts.out_free) begin
          state_nxt = sts.frame_end ? ST_BOX : ST_IDLE;
        end
      end
      ST_BOX: begin
        if (sts.out_free) begin
          state_nxt = sts.any_used ? ST_SCAN : ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (sts.idx_used && sts.out_free && sts.idx_final) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready  = 1'b1;
        cmd.accept = in_tvalid;
      end
      ST_EVAL:  cmd.eval  = 1'b1;
      ST_GROUP: cmd.group = 1'b1;
      ST_POINT: cmd.load_point = sts.out_free;
      ST_BOX: begin
        if (sts.out_free) begin
          cmd.load_box = 1'b1;
          cmd.clear    = !sts.any_used;
        end
      end
      ST_SCAN: begin
        if (!sts.idx_used) begin
          cmd.step = 1'b1;
        end else if (sts.out_free) begin
          cmd.load_rect = 1'b1;
          cmd.clear     = sts.idx_final;
          cmd.step      = !sts.idx_final;
        end
      end
      default: cmd = '0;
    endcase
  end

endmodule

### hw/rtl/idrf_datapath.sv
// ----------------------------------------------------------------------------
// idrf_datapath
// Position counters, bounding box, rectangle table and output register.
// ----------------------------------------------------------------------------
module idrf_datapath
  import idrf_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  cfg_t                   cfg,
  input  cmd_t                   cmd,
  output sts_t                   sts,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic [1:0]             out_tuser,
  output logic                   out_tlast
);

  // counters and latched position
  logic [XW-1:0] col_r, row_r, x_r, y_r;
  logic          fe_r;
  logic [EW-1:0] w_eff, h_eff;
  logic          row_end, frame_end_in;

  // bounding box
  logic          any_diff_r;
  logic [XW-1:0] box_l_r, box_t_r, box_r_r, box_b_r;

  // rectangle table
  logic [XW-1:0]    rx_r [RECTS];
  logic [XW-1:0]    ry_r [RECTS];
  logic [EW-1:0]    rw_r [RECTS];
  logic [EW-1:0]    rh_r [RECTS];
  logic [XW-1:0]    rx_nxt [RECTS];
  logic [XW-1:0]    ry_nxt [RECTS];
  logic [EW-1:0]    rw_nxt [RECTS];
  logic [EW-1:0]    rh_nxt [RECTS];
  logic [SW-1:0]    rr_w [RECTS];
  logic [SW-1:0]    rb_w [RECTS];
  logic [RECTS-1:0] used_r, used_nxt;
  logic [RECTS-1:0] match_r, match_nxt;
  logic [RECTS-1:0] hit_oh, free_v, free_oh;
  logic             ovf_r, ovf_nxt;
  logic [RIDX_W-1:0] idx_r;

  // output register
  logic              out_valid_r;
  kind_t             o_kind_r;
  logic [XW-1:0]     o_px_r, o_py_r;
  logic [EW-1:0]     o_ex_r, o_ey_r;
  logic              o_ovf_r, o_last_r;

  logic              out_free;
  logic              load_any;
  logic              grp_en;
  logic [SW:0]       d_w;
  logic [EW-1:0]     xd_w, yd_w;

  // frame position of the pixel on the input
  assign w_eff        = eff_size(cfg.frame_width);
  assign h_eff        = eff_size(cfg.frame_height);
  assign row_end      = {1'b0, col_r} >= (w_eff - EW'(1));
  assign frame_end_in = row_end && ({1'b0, row_r} >= (h_eff - EW'(1)));

  assign out_free = !out_valid_r || out_tready;
  assign load_any = cmd.load_point || cmd.load_box || cmd.load_rect;

  // status
  always_comb begin
    sts.in_diff      = in_tdata[PIX_W-1:0] != in_tdata[2*PIX_W-1:PIX_W];
    sts.in_frame_end = frame_end_in;
    sts.frame_end    = fe_r;
    sts.out_free     = out_free;
    sts.any_used     = |used_r;
    sts.idx_used     = used_r[idx_r];
    sts.idx_final    = ((used_r >> idx_r) >> 1) == '0;
  end

  // counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (cmd.accept) begin
      if (frame_end_in) begin
        col_r <= '0;
        row_r <= '0;
      end else if (row_end) begin
        col_r <= '0;
        row_r <= row_r + XW'(1);
      end else begin
        col_r <= col_r + XW'(1);
      end
    end
  end

  // latched position of the accepted pixel
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      x_r  <= col_r;
      y_r  <= row_r;
      fe_r <= frame_end_in;
    end
  end

  // bounding box
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      any_diff_r <= 1'b0;
      box_l_r    <= '0;
      box_t_r    <= '0;
      box_r_r    <= '0;
      box_b_r    <= '0;
    end else if (cmd.clear) begin
      any_diff_r <= 1'b0;
      box_l_r    <= '0;
      box_t_r    <= '0;
      box_r_r    <= '0;
      box_b_r    <= '0;
    end else if (cmd.eval) begin
      any_diff_r <= 1'b1;
      if (!any_diff_r) begin
        box_l_r <= x_r;
        box_r_r <= x_r;
        box_t_r <= y_r;
        box_b_r <= y_r;
      end else begin
        if (x_r < box_l_r) box_l_r <= x_r;
        if (x_r > box_r_r) box_r_r <= x_r;
        if (y_r < box_t_r) box_t_r <= y_r;
        if (y_r > box_b_r) box_b_r <= y_r;
      end
    end
  end

  // proximity test, one lane per entry
  assign d_w  = (SW + 1)'(cfg.near_distance);
  assign xd_w = {1'b0, x_r} + EW'(cfg.near_distance);
  assign yd_w = {1'b0, y_r} + EW'(cfg.near_distance);

  always_comb begin
    for (int i = 0; i < RECTS; i++) begin
      rr_w[i]      = SW'(rx_r[i]) + SW'(rw_r[i]);
      rb_w[i]      = SW'(ry_r[i]) + SW'(rh_r[i]);
      match_nxt[i] = used_r[i] &&
        ((({1'b0, rr_w[i]} + d_w >= (SW + 1)'(x_r)) &&
          ({1'b0, rb_w[i]} + d_w >= (SW + 1)'(y_r))) ||
         ((x_r < rx_r[i]) && (y_r < ry_r[i]) &&
          ({1'b0, rx_r[i]} <= xd_w) && ({1'b0, ry_r[i]} <= yd_w)));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      match_r <= match_nxt;
    end
  end

  // first matching entry and first free entry
  assign grp_en  = cmd.group && cfg.mark_enable;
  assign hit_oh  = match_r & (~match_r + RECTS'(1));
  assign free_v  = ~used_r;
  assign free_oh = free_v & (~free_v + RECTS'(1));

  // grouping: extend the hit entry, or allocate a 1x1 entry
  always_comb begin
    used_nxt = used_r;
    ovf_nxt  = ovf_r;
    for (int i = 0; i < RECTS; i++) begin
      rx_nxt[i] = rx_r[i];
      ry_nxt[i] = ry_r[i];
      rw_nxt[i] = rw_r[i];
      rh_nxt[i] = rh_r[i];
      if (grp_en && hit_oh[i]) begin
        if (rr_w[i] < SW'(x_r)) begin
          rw_nxt[i] = {1'b0, x_r} - {1'b0, rx_r[i]};
        end else if (rx_r[i] > x_r) begin
          rw_nxt[i] = rw_r[i] + ({1'b0, rx_r[i]} - {1'b0, x_r});
          rx_nxt[i] = x_r;
        end
        if (rb_w[i] < SW'(y_r)) begin
          rh_nxt[i] = {1'b0, y_r} - {1'b0, ry_r[i]};
        end
      end else if (grp_en && (match_r == '0) && free_oh[i]) begin
        rx_nxt[i]   = x_r;
        ry_nxt[i]   = y_r;
        rw_nxt[i]   = EW'(1);
        rh_nxt[i]   = EW'(1);
        used_nxt[i] = 1'b1;
      end
    end
    if (grp_en && (match_r == '0) && (free_v == '0)) begin
      ovf_nxt = 1'b1;
    end
  end

  // table payload
  always_ff @(posedge clk) begin
    for (int i = 0; i < RECTS; i++) begin
      rx_r[i] <= rx_nxt[i];
      ry_r[i] <= ry_nxt[i];
      rw_r[i] <= rw_nxt[i];
      rh_r[i] <= rh_nxt[i];
    end
  end

  // table control and readout index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
      ovf_r  <= 1'b0;
      idx_r  <= '0;
    end else begin
      if (cmd.clear) begin
        used_r <= '0;
        ovf_r  <= 1'b0;
      end else begin
        used_r <= used_nxt;
        ovf_r  <= ovf_nxt;
      end
      if (cmd.load_box) begin
        idx_r <= '0;
      end else if (cmd.step) begin
        idx_r <= idx_r + RIDX_W'(1);
      end
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_any) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    priority if (cmd.load_point) begin
      o_kind_r <= KIND_POINT;
      o_px_r   <= x_r;
      o_py_r   <= y_r;
      o_ex_r   <= '0;
      o_ey_r   <= '0;
      o_ovf_r  <= ovf_r;
      o_last_r <= 1'b0;
    end else if (cmd.load_box) begin
      o_kind_r <= any_diff_r ? KIND_BOX : KIND_NODIFF;
      o_px_r   <= box_l_r;
      o_py_r   <= box_t_r;
      o_ex_r   <= {1'b0, box_r_r};
      o_ey_r   <= {1'b0, box_b_r};
      o_ovf_r  <= ovf_r;
      o_last_r <= !(|used_r);
    end else if (cmd.load_rect) begin
      o_kind_r <= KIND_RECT;
      o_px_r   <= rx_r[idx_r];
      o_py_r   <= ry_r[idx_r];
      o_ex_r   <= rw_r[idx_r];
      o_ey_r   <= rh_r[idx_r];
      o_ovf_r  <= ovf_r;
      o_last_r <= sts.idx_final;
    end else begin
      o_kind_r <= o_kind_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = o_kind_r;
  assign out_tlast  = o_last_r;
  assign out_tdata  = {OUT_PAD_W'(0), o_ovf_r, o_ey_r, o_ex_r, o_py_r, o_px_r};

  // overflow only appears when every entry was taken
  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ovf_r) |-> $past(&used_r))
    else $error("table overflow flagged with a free entry");

  // frame clear empties the table and the box
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |=> (used_r == '0) && !ovf_r && !any_diff_r)
    else $error("frame state not cleared");

  // a result is only loaded into a free output register
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    load_any |-> (!out_valid_r || out_tready))
    else $error("result overwrites a pending transfer");

  // readout only reports entries in use
  a_rect_used: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_rect |-> used_r[idx_r])
    else $error("rectangle reported from an unused entry");

endmodule

### hw/rtl/image_diff_region_finder_unit.sv
// ----------------------------------------------------------------------------
// image_diff_region_finder_unit
// Compares two frames pixel by pixel, reports points, bounding box, rectangles.
// ----------------------------------------------------------------------------
// Equal pixel pairs transfer at one per cycle while the sequencer is idle; a
// differing pair holds the input through accept, box and proximity match,
// group update and point load, the point being loaded once the output is free.
// Frame end adds the box result, then a serial table readout of each entry
// up to the last used one (at most 16), which also waits for a free output.
// Synchronous active-low reset restores register defaults and empties the
// table; no clearing pass is needed.
module image_diff_region_finder_unit
  import idrf_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // pixel pairs
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // pixel_a[23:0], pixel_b[47:24]
  // results
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // pos_x[11:0], pos_y[23:12],
                                             // extent_x[36:24], extent_y[49:37],
                                             // overflow[50], zero pad
  output logic [1:0]             out_tuser,  // kind[1:0]
  output logic                   out_tlast,
  // configuration writes
  input  logic                   cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [EW-1:0]          cfg_wdata
);

  cfg_t cfg_r;
  cmd_t cmd;
  sts_t sts;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_width   <= FRAME_WIDTH_RST;
      cfg_r.frame_height  <= FRAME_HEIGHT_RST;
      cfg_r.mark_enable   <= 1'b0;
      cfg_r.near_distance <= NEAR_DIST_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_FRAME_WIDTH:  cfg_r.frame_width   <= cfg_wdata;
        REG_FRAME_HEIGHT: cfg_r.frame_height  <= cfg_wdata;
        REG_MARK_ENABLE:  cfg_r.mark_enable   <= cfg_wdata[0];
        REG_NEAR_DIST:    cfg_r.near_distance <= cfg_wdata[DIST_W-1:0];
      endcase
    end
  end

  // sequencer
  idrf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath
  idrf_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
